// ===== src/dtef_pkg.sv =====
// Package for the decimal string to extended float converter.
// Holds the channel payload types and fixed constants; no dependencies.
package dtef_pkg;

  typedef struct packed {
    logic [7:0] digit_char;
    logic       is_end;
  } in_item_t;

  typedef struct packed {
    logic [31:0] mantissa_high;
    logic [31:0] mantissa_low;
    logic [15:0] biased_exponent;
  } out_item_t;

  localparam logic [15:0] EXP_BASE    = 16'h405E;
  localparam logic [31:0] TOP_BIT     = 32'h8000_0000;
  localparam int          WORD_BITS   = 32;
  localparam int          NIBBLE_BITS = 4;
  localparam logic [1:0]  LAST_WORD   = 2'd2;

endpackage

// ===== src/decimal_to_extended_float_core.sv =====
// Decimal digit string to x87 extended significand and exponent; uses dtef_pkg.
// A digit transfer is accepted in idle, then takes three passes of the
// shared 32-bit multiply-by-ten adder, one per accumulator word. An end item
// runs word shifts, then one-bit normalize shifts, then round.
// Items are taken one at a time; in_stall is high until the current item is done.
// Reset clears the accumulator, the sequencer and the output valid.
module decimal_to_extended_float_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  dtef_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dtef_pkg::out_item_t  out_data
);
  import dtef_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MUL   = 5'b00010,
    S_WORD  = 5'b00100,
    S_BIT   = 5'b01000,
    S_ROUND = 5'b10000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [3*WORD_BITS-1:0]     acc_r, acc_nxt;
  logic [1:0]                 cnt_r, cnt_nxt;
  logic [NIBBLE_BITS-1:0]     carry_r, carry_nxt;
  logic [15:0]                exp_r, exp_nxt;
  logic                       out_valid_r, out_valid_nxt;
  out_item_t                  out_data_r, out_data_nxt;

  logic [WORD_BITS+3:0]       prod;
  logic [2*WORD_BITS:0]       rsum;
  logic                       acc_zero;
  logic                       out_free;

  // Shared unit: low accumulator word times ten plus the incoming carry.
  assign prod = ({4'b0, acc_r[WORD_BITS-1:0]} << 3)
              + ({4'b0, acc_r[WORD_BITS-1:0]} << 1)
              + {{WORD_BITS{1'b0}}, carry_r};

  assign rsum     = {1'b0, acc_r[3*WORD_BITS-1:WORD_BITS]}
                  + {{2*WORD_BITS{1'b0}}, acc_r[WORD_BITS-1]};
  assign acc_zero = (acc_r == '0);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    carry_nxt     = carry_r;
    exp_nxt       = exp_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cnt_nxt = 2'd0;
          if (in_data.is_end) begin
            exp_nxt   = EXP_BASE;
            state_nxt = S_WORD;
          end else begin
            carry_nxt = in_data.digit_char[NIBBLE_BITS-1:0];
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        // Words rotate through the low slot; after three passes they are home.
        acc_nxt   = {prod[WORD_BITS-1:0], acc_r[3*WORD_BITS-1:WORD_BITS]};
        carry_nxt = prod[WORD_BITS+3:WORD_BITS];
        cnt_nxt   = cnt_r + 2'd1;
        if (cnt_r == LAST_WORD) begin
          state_nxt = S_IDLE;
        end
      end
      S_WORD: begin
        if (acc_zero) begin
          state_nxt = S_ROUND;
        end else if (acc_r[3*WORD_BITS-1:2*WORD_BITS] == '0 && cnt_r != LAST_WORD) begin
          acc_nxt = {acc_r[2*WORD_BITS-1:0], {WORD_BITS{1'b0}}};
          exp_nxt = exp_r - 16'(WORD_BITS);
          cnt_nxt = cnt_r + 2'd1;
        end else begin
          state_nxt = S_BIT;
        end
      end
      S_BIT: begin
        if (acc_r[3*WORD_BITS-1]) begin
          state_nxt = S_ROUND;
        end else begin
          acc_nxt = {acc_r[3*WORD_BITS-2:0], 1'b0};
          exp_nxt = exp_r - 16'd1;
        end
      end
      S_ROUND: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (rsum[2*WORD_BITS]) begin
            out_data_nxt.mantissa_high   = TOP_BIT;
            out_data_nxt.biased_exponent = exp_r + 16'd1;
          end else begin
            out_data_nxt.mantissa_high   = rsum[2*WORD_BITS-1:WORD_BITS];
            out_data_nxt.biased_exponent = exp_r;
          end
          out_data_nxt.mantissa_low = rsum[WORD_BITS-1:0];
          acc_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      acc_r       <= '0;
      cnt_r       <= '0;
      carry_r     <= '0;
      exp_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      carry_r     <= carry_nxt;
      exp_r       <= exp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
